@@ hw/rtl/fps_pkg.sv @@
// fps_pkg: shared types and constants for the fitness proportionate selector
// field widths, opcode and mode codes, register indexes, sequencer states
// no dependencies
`default_nettype none
package fps_pkg;

  localparam int MAX_ENTRIES_DEF   = 256;
  localparam int SCORE_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int IDX_W       = 8;
  localparam int SCORE_W     = 24;
  localparam int FRAC_W      = 16;
  localparam int TOTAL_W     = 32;
  localparam int MODE_W      = 2;
  localparam int POP_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SELECT = 1'b1
  } opcode_t;

  localparam logic [MODE_W-1:0] MODE_RAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FITNESS_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_IS_BEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_COUNT    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MINMAX,
    ST_TOTAL,
    ST_MULT,
    ST_PICK
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/fps_item_if.sv @@
// fps_item_if: input item channel, valid/ready with opcode and write/select payload
// depends on fps_pkg
`default_nettype none
interface fps_item_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [fps_pkg::IDX_W-1:0]    entry_index;
  logic [fps_pkg::SCORE_W-1:0]  score;
  logic [fps_pkg::FRAC_W-1:0]   random_fraction;

  modport source (output valid, output opcode, output entry_index, output score,
                  output random_fraction, input ready);
  modport sink   (input valid, input opcode, input entry_index, input score,
                  input random_fraction, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fps_result_if.sv @@
// fps_result_if: result channel, valid/ready with selection result payload
// depends on fps_pkg
`default_nettype none
interface fps_result_if;
  logic                         valid;
  logic                         ready;
  logic [fps_pkg::IDX_W-1:0]    selected_index;
  logic [fps_pkg::IDX_W-1:0]    best_index;
  logic [fps_pkg::IDX_W-1:0]    worst_index;
  logic [fps_pkg::TOTAL_W-1:0]  total_fitness;

  modport source (output valid, output selected_index, output best_index,
                  output worst_index, output total_fitness, input ready);
  modport sink   (input valid, input selected_index, input best_index,
                  input worst_index, input total_fitness, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fps_cfg_if.sv @@
// fps_cfg_if: configuration write channel, valid/ready with register index and data
// depends on fps_pkg
`default_nettype none
interface fps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fps_pkg::CFG_IDX_W-1:0]   index;
  logic [fps_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fitness_proportionate_selector.sv @@
// fitness_proportionate_selector: roulette wheel selection over a stored score table
// depends on fps_pkg, fps_item_if, fps_result_if, fps_cfg_if, fps_ram
//
// channel  modport  beat carries
// in_ch    sink     opcode, entry_index, score, random_fraction
// out_ch   source   selected_index, best_index, worst_index, total_fitness
// cfg_ch   sink     index, data (always ready)
//
// a write beat gives an all-zero result that passes through the pending slot and the output register
// a select over n entries makes three passes through the score ram port
// (best/worst, total, pick) and a bit-serial threshold multiply; the pick
// pass stops at the first hit
// synchronous active-low reset; the score ram holds no reset value
// one finished result may wait on out_ch while the next beat is taken
`default_nettype none
module fitness_proportionate_selector #(
  parameter int MAX_ENTRIES   = fps_pkg::MAX_ENTRIES_DEF,
  parameter int SCORE_BITS    = fps_pkg::SCORE_BITS_DEF,
  parameter int FRACTION_BITS = fps_pkg::FRACTION_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  fps_item_if.sink     in_ch,
  fps_result_if.source out_ch,
  fps_cfg_if.sink      cfg_ch
);

  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int NW     = $clog2(MAX_ENTRIES + 1);
  localparam int FIT_W  = (SCORE_BITS > NW) ? SCORE_BITS : NW;
  localparam int TOT_W  = FIT_W + NW;
  localparam int PROD_W = TOT_W + FRACTION_BITS;
  localparam int MCW    = $clog2(FRACTION_BITS + 1);
  localparam int PCW    = (fps_pkg::POP_W > NW) ? fps_pkg::POP_W : NW;
  localparam int IW     = fps_pkg::IDX_W;
  localparam int OTW    = fps_pkg::TOTAL_W;

  // configuration
  logic [fps_pkg::MODE_W-1:0] mode_r;
  logic                       hib_r;
  logic [fps_pkg::POP_W-1:0]  pop_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fps_pkg::MODE_RAW;
      hib_r  <= 1'b1;
      pop_r  <= fps_pkg::POP_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        fps_pkg::CFG_FITNESS_MODE: mode_r <= cfg_ch.data[fps_pkg::MODE_W-1:0];
        fps_pkg::CFG_HIGH_IS_BEST: hib_r  <= cfg_ch.data[0];
        fps_pkg::CFG_POP_COUNT:    pop_r  <= cfg_ch.data[fps_pkg::POP_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  fps_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]            rd_cnt_r, rd_cnt_nxt;
  logic                     dat_vld_r;
  logic [AW-1:0]            dat_idx_r;
  logic [NW-1:0]            n_r, n_nxt;
  logic [SCORE_BITS-1:0]    best_sc_r, best_sc_nxt, worst_sc_r, worst_sc_nxt;
  logic [AW-1:0]            best_idx_r, best_idx_nxt, worst_idx_r, worst_idx_nxt;
  logic [TOT_W-1:0]         tot_r, tot_nxt, run_r, run_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt, mcand_r, mcand_nxt;
  logic [FRACTION_BITS-1:0] frac_r, frac_nxt;
  logic [MCW-1:0]           mul_cnt_r, mul_cnt_nxt;
  logic                     pend_vld_r, pend_vld_nxt, out_vld_r, out_vld_nxt;
  logic [IW-1:0]            pend_sel_r, pend_best_r, pend_worst_r;
  logic [OTW-1:0]           pend_tot_r;
  logic [IW-1:0]            out_sel_r, out_best_r, out_worst_r;
  logic [OTW-1:0]           out_tot_r;

  logic                     in_ready, in_acc, ram_we, rd_issue, scan, last, mv;
  logic                     fin, hit, better, worse;
  logic [IW-1:0]            fin_sel, fin_best, fin_worst;
  logic [OTW-1:0]           fin_tot;
  logic [SCORE_BITS-1:0]    rdata;
  logic [FIT_W-1:0]         fit;
  logic [TOT_W-1:0]         tot_sum, run_sum, thresh;
  logic [PCW-1:0]           pop_ext;
  logic [63:0]              tot_ext;

  assign in_ready    = (state_r == fps_pkg::ST_IDLE) && !pend_vld_r;
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign ram_we      = in_acc && (in_ch.opcode == fps_pkg::OP_WRITE) &&
                       (32'(in_ch.entry_index) < 32'(MAX_ENTRIES));

  fps_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_ENTRIES)) u_score_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_ch.entry_index)),
    .wdata (SCORE_BITS'(in_ch.score)),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (rdata)
  );

  assign scan     = (state_r == fps_pkg::ST_MINMAX) || (state_r == fps_pkg::ST_TOTAL) ||
                    (state_r == fps_pkg::ST_PICK);
  assign rd_issue = scan && (rd_cnt_r != n_r);
  assign last     = (dat_idx_r == AW'(n_r - NW'(1)));
  assign pop_ext  = PCW'(pop_r);
  assign thresh   = prod_r[PROD_W-1:FRACTION_BITS];
  assign tot_sum  = tot_r + TOT_W'(fit);
  assign run_sum  = run_r + TOT_W'(fit);
  assign hit      = run_sum > thresh;
  assign tot_ext  = 64'(tot_r);
  assign better   = hib_r ? (rdata > best_sc_r) : (rdata < best_sc_r);
  assign worse    = hib_r ? (rdata < worst_sc_r) : (rdata > worst_sc_r);
  assign mv       = pend_vld_r && (!out_vld_r || out_ch.ready);

  always_comb begin
    case (mode_r)
      fps_pkg::MODE_RAW:  fit = FIT_W'(rdata);
      fps_pkg::MODE_DIFF: fit = (worst_sc_r >= rdata) ? FIT_W'(worst_sc_r - rdata)
                                                      : FIT_W'(rdata - worst_sc_r);
      default:            fit = FIT_W'(n_r - NW'(dat_idx_r));
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_issue ? rd_cnt_r + NW'(1) : rd_cnt_r;
    n_nxt         = n_r;
    best_sc_nxt   = best_sc_r;
    worst_sc_nxt  = worst_sc_r;
    best_idx_nxt  = best_idx_r;
    worst_idx_nxt = worst_idx_r;
    tot_nxt       = tot_r;
    run_nxt       = run_r;
    prod_nxt      = prod_r;
    mcand_nxt     = mcand_r;
    frac_nxt      = frac_r;
    mul_cnt_nxt   = mul_cnt_r;
    fin           = 1'b0;
    fin_sel       = '0;
    fin_best      = '0;
    fin_worst     = '0;
    fin_tot       = '0;
    case (state_r)
      fps_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.opcode == fps_pkg::OP_SELECT) begin
            state_nxt  = fps_pkg::ST_MINMAX;
            rd_cnt_nxt = '0;
            tot_nxt    = '0;
            frac_nxt   = FRACTION_BITS'(in_ch.random_fraction);
            if (pop_ext == '0) begin
              n_nxt = NW'(1);
            end else if (pop_ext > PCW'(MAX_ENTRIES)) begin
              n_nxt = NW'(MAX_ENTRIES);
            end else begin
              n_nxt = NW'(pop_ext);
            end
          end else begin
            fin = 1'b1;
          end
        end
      end
      fps_pkg::ST_MINMAX: begin
        if (dat_vld_r) begin
          if (dat_idx_r == '0) begin
            best_sc_nxt   = rdata;
            worst_sc_nxt  = rdata;
            best_idx_nxt  = '0;
            worst_idx_nxt = '0;
          end else begin
            if (better) begin
              best_sc_nxt  = rdata;
              best_idx_nxt = dat_idx_r;
            end
            if (worse) begin
              worst_sc_nxt  = rdata;
              worst_idx_nxt = dat_idx_r;
            end
          end
          if (last) begin
            state_nxt  = fps_pkg::ST_TOTAL;
            rd_cnt_nxt = '0;
          end
        end
      end
      fps_pkg::ST_TOTAL: begin
        if (dat_vld_r) begin
          tot_nxt = tot_sum;
          if (last) begin
            state_nxt   = fps_pkg::ST_MULT;
            prod_nxt    = '0;
            mcand_nxt   = PROD_W'(tot_sum);
            mul_cnt_nxt = '0;
          end
        end
      end
      fps_pkg::ST_MULT: begin
        if (mul_cnt_r == MCW'(FRACTION_BITS)) begin
          state_nxt  = fps_pkg::ST_PICK;
          rd_cnt_nxt = '0;
          run_nxt    = '0;
        end else begin
          if (frac_r[0]) begin
            prod_nxt = prod_r + mcand_r;
          end
          mcand_nxt   = mcand_r << 1;
          frac_nxt    = frac_r >> 1;
          mul_cnt_nxt = mul_cnt_r + MCW'(1);
        end
      end
      fps_pkg::ST_PICK: begin
        if (dat_vld_r) begin
          run_nxt = run_sum;
          if (hit || last) begin
            state_nxt = fps_pkg::ST_IDLE;
            fin       = 1'b1;
            fin_sel   = hit ? IW'(dat_idx_r) : '0;
            fin_best  = IW'(best_idx_r);
            fin_worst = IW'(worst_idx_r);
            fin_tot   = (|tot_ext[63:32]) ? '1 : tot_ext[31:0];
          end
        end
      end
      default: state_nxt = fps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (fin) begin
      pend_vld_nxt = 1'b1;
    end else if (mv) begin
      pend_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (mv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fps_pkg::ST_IDLE;
      rd_cnt_r   <= '0;
      dat_vld_r  <= 1'b0;
      mul_cnt_r  <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      dat_vld_r  <= rd_issue;
      mul_cnt_r  <= mul_cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dat_idx_r   <= rd_cnt_r[AW-1:0];
    n_r         <= n_nxt;
    best_sc_r   <= best_sc_nxt;
    worst_sc_r  <= worst_sc_nxt;
    best_idx_r  <= best_idx_nxt;
    worst_idx_r <= worst_idx_nxt;
    tot_r       <= tot_nxt;
    run_r       <= run_nxt;
    prod_r      <= prod_nxt;
    mcand_r     <= mcand_nxt;
    frac_r      <= frac_nxt;
    if (fin) begin
      pend_sel_r   <= fin_sel;
      pend_best_r  <= fin_best;
      pend_worst_r <= fin_worst;
      pend_tot_r   <= fin_tot;
    end
    if (mv) begin
      out_sel_r   <= pend_sel_r;
      out_best_r  <= pend_best_r;
      out_worst_r <= pend_worst_r;
      out_tot_r   <= pend_tot_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.selected_index = out_sel_r;
  assign out_ch.best_index     = out_best_r;
  assign out_ch.worst_index    = out_worst_r;
  assign out_ch.total_fitness  = out_tot_r;

`ifndef NO_ASSERTIONS
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !pend_vld_r)
    else $error("result finished while pending slot full");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.opcode == fps_pkg::OP_WRITE)) |=> pend_vld_r)
    else $error("write beat gave no result");

  a_select_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.opcode == fps_pkg::OP_SELECT)) |=>
      ((state_r == fps_pkg::ST_MINMAX) && (rd_cnt_r == '0) && !dat_vld_r))
    else $error("select did not start a clean pass");

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dat_vld_r && scan) |-> (NW'(dat_idx_r) < n_r))
    else $error("read beyond population");

  a_mult_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == fps_pkg::ST_MULT) && (state_nxt == fps_pkg::ST_PICK)) |->
      (mul_cnt_r == MCW'(FRACTION_BITS)))
    else $error("threshold multiply cut short");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/fps_ram.sv @@
// fps_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module fps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for fitness_proportionate_selector, with a queue-fed driver,
// a stalling receiver, a monitor and an in-bench roulette predictor
// depends on fps_pkg, fps_item_if, fps_result_if, fps_cfg_if and the selector rtl
module tb;

  localparam logic [fps_pkg::MODE_W-1:0] MODE_RANK_ALT = 2'd3;
  localparam int ENTRIES      = 256;
  localparam int ITEM_TARGET  = 550;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 3 * ENTRIES + fps_pkg::FRAC_W + 16;

  typedef struct packed {
    fps_pkg::opcode_t                op;
    logic [fps_pkg::IDX_W-1:0]       idx;
    logic [fps_pkg::SCORE_W-1:0]     score;
    logic [fps_pkg::FRAC_W-1:0]      frac;
  } sel_item_t;

  typedef struct packed {
    logic [fps_pkg::IDX_W-1:0]       selected_index;
    logic [fps_pkg::IDX_W-1:0]       best_index;
    logic [fps_pkg::IDX_W-1:0]       worst_index;
    logic [fps_pkg::TOTAL_W-1:0]     total_fitness;
  } sel_result_t;

  logic clk;
  logic rst_n;

  fps_item_if   in_ch ();
  fps_result_if out_ch ();
  fps_cfg_if    cfg_ch ();

  fitness_proportionate_selector u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  logic [fps_pkg::SCORE_W-1:0] score_mem [ENTRIES];
  logic [fps_pkg::MODE_W-1:0]  mode_q = fps_pkg::MODE_RAW;
  logic                        hib_q  = 1'b1;
  logic [fps_pkg::POP_W-1:0]   pop_q  = 9'd1;

  sel_item_t   item_backlog [$];
  sel_result_t pending_picks [$];
  sel_item_t   cur_item;
  sel_result_t want;

  bit          written_map [ENTRIES];
  int          items_made   = 0;
  int          err_count    = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_wait      = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;
  bit          long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_count(input logic [fps_pkg::POP_W-1:0] p);
    int n;
    n = int'(p);
    if (n == 0) n = 1;
    if (n > ENTRIES) n = ENTRIES;
    return n;
  endfunction

  function automatic logic [63:0] fitness_of(input int i, input int n,
                                             input logic [fps_pkg::SCORE_W-1:0] worst_s);
    logic [63:0] s;
    logic [63:0] w;
    s = 64'(score_mem[i]);
    w = 64'(worst_s);
    if (mode_q == fps_pkg::MODE_RAW) return s;
    if (mode_q == fps_pkg::MODE_DIFF) return (w >= s) ? (w - s) : (s - w);
    return 64'(n - i);
  endfunction

  function automatic sel_result_t roulette_pick(input sel_item_t it);
    sel_result_t res;
    int          n;
    int          i;
    int          best;
    int          worst;
    int          sel;
    bit          hit;
    logic [63:0] total;
    logic [63:0] thresh;
    logic [63:0] run;
    res = '0;
    if (it.op == fps_pkg::OP_WRITE) begin
      score_mem[it.idx] = it.score;
      return res;
    end
    n = eff_count(pop_q);
    best = 0;
    worst = 0;
    for (i = 1; i < n; i++) begin
      if (hib_q) begin
        if (score_mem[best] < score_mem[i]) best = i;
        if (score_mem[worst] > score_mem[i]) worst = i;
      end else begin
        if (score_mem[best] > score_mem[i]) best = i;
        if (score_mem[worst] < score_mem[i]) worst = i;
      end
    end
    total = 0;
    for (i = 0; i < n; i++) total += fitness_of(i, n, score_mem[worst]);
    thresh = (64'(it.frac) * total) >> fps_pkg::FRAC_W;
    sel = 0;
    run = 0;
    hit = 1'b0;
    for (i = 0; i < n; i++) begin
      run += fitness_of(i, n, score_mem[worst]);
      if (!hit && run > thresh) begin
        sel = i;
        hit = 1'b1;
      end
    end
    res.selected_index = sel[fps_pkg::IDX_W-1:0];
    res.best_index     = best[fps_pkg::IDX_W-1:0];
    res.worst_index    = worst[fps_pkg::IDX_W-1:0];
    res.total_fitness  = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [fps_pkg::SCORE_W-1:0] rand_score();
    int unsigned                 r;
    logic [fps_pkg::SCORE_W-1:0] v;
    r = $urandom_range(0, 99);
    v = fps_pkg::SCORE_W'($urandom);
    if (r < 10) v = '0;
    else if (r < 20) v = '1;
    else if (r < 50) v = fps_pkg::SCORE_W'(v[2:0]);
    return v;
  endfunction

  function automatic logic [fps_pkg::FRAC_W-1:0] rand_frac();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return fps_pkg::FRAC_W'($urandom);
  endfunction

  task automatic report(input string what);
    err_count++;
    if (err_count <= 200) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic push_write(input logic [fps_pkg::IDX_W-1:0] idx,
                            input logic [fps_pkg::SCORE_W-1:0] sc);
    sel_item_t it;
    it.op = fps_pkg::OP_WRITE;
    it.idx = idx;
    it.score = sc;
    it.frac = fps_pkg::FRAC_W'($urandom);
    written_map[idx] = 1'b1;
    item_backlog.insert(item_backlog.size(), it);
    items_made++;
  endtask

  task automatic push_select(input logic [fps_pkg::FRAC_W-1:0] fr);
    sel_item_t it;
    it.op = fps_pkg::OP_SELECT;
    it.idx = fps_pkg::IDX_W'($urandom);
    it.score = fps_pkg::SCORE_W'($urandom);
    it.frac = fr;
    item_backlog.insert(item_backlog.size(), it);
    items_made++;
  endtask

  task automatic ensure_written(input int n);
    int i;
    for (i = 0; i < n; i++)
      if (!written_map[i]) push_write(i[fps_pkg::IDX_W-1:0], rand_score());
  endtask

  // settle at the falling edge, then hand back at the next rising edge
  task automatic wait_idle();
    @(negedge clk);
    while (item_backlog.size() != 0 || in_ch.valid || pending_picks.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [fps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fps_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      fps_pkg::CFG_FITNESS_MODE: mode_q = val[fps_pkg::MODE_W-1:0];
      fps_pkg::CFG_HIGH_IS_BEST: hib_q  = val[0];
      fps_pkg::CFG_POP_COUNT:    pop_q  = val[fps_pkg::POP_W-1:0];
      default: ;
    endcase
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid           <= 1'b0;
      in_ch.opcode          <= fps_pkg::OP_WRITE;
      in_ch.entry_index     <= '0;
      in_ch.score           <= '0;
      in_ch.random_fraction <= '0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        pending_picks.insert(pending_picks.size(), roulette_pick(cur_item));
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          cur_item = item_backlog.pop_front();
          in_ch.valid           <= 1'b1;
          in_ch.opcode          <= cur_item.op;
          in_ch.entry_index     <= cur_item.idx;
          in_ch.score           <= cur_item.score;
          in_ch.random_fraction <= cur_item.frac;
          tx_gap = tx_calm ? 0 : gap_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, long hold counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_wait = LONG_HOLD;
      end else if (out_ch.valid && out_ch.ready && !rx_calm) begin
        rx_wait = gap_len();
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_picks.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = pending_picks.pop_front();
        if (out_ch.selected_index !== want.selected_index)
          report($sformatf("selected_index got %0d want %0d",
                           out_ch.selected_index, want.selected_index));
        if (out_ch.best_index !== want.best_index)
          report($sformatf("best_index got %0d want %0d",
                           out_ch.best_index, want.best_index));
        if (out_ch.worst_index !== want.worst_index)
          report($sformatf("worst_index got %0d want %0d",
                           out_ch.worst_index, want.worst_index));
        if (out_ch.total_fitness !== want.total_fitness)
          report($sformatf("total_fitness got %0d want %0d",
                           out_ch.total_fitness, want.total_fitness));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int                         phase;
    int                         n;
    int                         len;
    int                         k;
    int unsigned                r;
    logic [fps_pkg::POP_W-1:0]  pop;
    logic [fps_pkg::MODE_W-1:0] mode;
    logic [6:0]                 noise7;
    logic [7:0]                 noise8;

    rst_n        <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= fps_pkg::CFG_FITNESS_MODE;
    cfg_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single entry, zero total
    push_write(8'd0, 24'h0);
    push_select(16'h0000);
    push_write(8'd1, 24'hFFFFFF);
    push_write(8'd2, 24'h0);
    push_write(8'd3, 24'hFFFFFF);
    push_write(8'd255, fps_pkg::SCORE_W'($urandom));
    write_reg(fps_pkg::CFG_POP_COUNT, 9'd4);
    push_select(16'hFFFF);
    push_select(16'h0000);
    push_select(16'h8000);
    write_reg(fps_pkg::CFG_FITNESS_MODE, fps_pkg::CFG_DATA_W'(fps_pkg::MODE_DIFF));
    push_select(16'hFFFF);
    push_select(16'h4000);
    write_reg(fps_pkg::CFG_HIGH_IS_BEST, 9'd0);
    push_select(16'hFFFF);
    push_select(16'h1234);
    write_reg(fps_pkg::CFG_FITNESS_MODE, fps_pkg::CFG_DATA_W'(fps_pkg::MODE_RANK));
    push_select(16'hFFFF);
    push_select(16'h0000);
    write_reg(fps_pkg::CFG_FITNESS_MODE, fps_pkg::CFG_DATA_W'(MODE_RANK_ALT));
    push_select(16'h8000);
    // zero count acts as one entry
    write_reg(fps_pkg::CFG_POP_COUNT, 9'd0);
    push_select(16'hC000);
    // equal scores: ties and zero total in difference mode
    write_reg(fps_pkg::CFG_POP_COUNT, 9'd2);
    push_write(8'd0, 24'd5);
    push_write(8'd1, 24'd5);
    write_reg(fps_pkg::CFG_FITNESS_MODE, fps_pkg::CFG_DATA_W'(fps_pkg::MODE_DIFF));
    push_select(16'hFFFF);
    write_reg(fps_pkg::CFG_FITNESS_MODE, fps_pkg::CFG_DATA_W'(fps_pkg::MODE_RAW));
    write_reg(fps_pkg::CFG_HIGH_IS_BEST, 9'd1);
    push_select(16'h7FFF);

    // random phases
    phase = 0;
    while (items_made < ITEM_TARGET) begin
      case (phase)
        0:       pop = 9'd511;
        1:       pop = 9'd256;
        2:       pop = fps_pkg::POP_W'($urandom_range(257, 510));
        default: pop = ($urandom_range(0, 9) == 0) ? fps_pkg::POP_W'($urandom_range(17, 256))
                                                  : fps_pkg::POP_W'($urandom_range(1, 16));
      endcase
      n = eff_count(pop);
      mode = ($urandom_range(0, 9) == 0) ? MODE_RANK_ALT
                                         : fps_pkg::MODE_W'($urandom_range(0, 2));
      noise7 = 7'($urandom);
      noise8 = 8'($urandom);
      write_reg(fps_pkg::CFG_FITNESS_MODE, {noise7, mode});
      write_reg(fps_pkg::CFG_HIGH_IS_BEST, {noise8, 1'($urandom_range(0, 1))});
      write_reg(fps_pkg::CFG_POP_COUNT, pop);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phase == 4) begin
        tx_calm = 1'b1;
        rx_calm = 1'b0;
        long_hold_req = 1'b1;
      end
      ensure_written(n);
      len = (n > 32) ? 8 : $urandom_range(25, 50);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 55) push_select(rand_frac());
        else if ($urandom_range(0, 99) < 85)
          push_write(fps_pkg::IDX_W'($urandom_range(0, n - 1)), rand_score());
        else
          push_write(fps_pkg::IDX_W'($urandom_range(0, ENTRIES - 1)), rand_score());
      end
      phase++;
    end

    wait_idle();
    tx_calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

@@ fitness_proportionate_selector.f @@
hw/rtl/fps_pkg.sv
hw/rtl/fps_item_if.sv
hw/rtl/fps_result_if.sv
hw/rtl/fps_cfg_if.sv
hw/rtl/fps_ram.sv
hw/rtl/fitness_proportionate_selector.sv
tb/tb.sv
